[hw/rtl/fdae_pkg.sv]
// Fibonacci delta audio encoder: shared constants, types and the step table.
// No dependencies; imported by fibonacci_delta_audio_encoder.
package fdae_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned CODE_BITS      = 4;
    localparam int unsigned NUM_CODES      = 1 << CODE_BITS;
    localparam int unsigned Q_DEPTH        = 4;
    localparam int unsigned Q_PTR_BITS     = 2;
    localparam int unsigned MAX_RESULTS    = 3;

    localparam logic [7:0]         PAD_BYTE  = 8'h00;
    localparam logic signed [10:0] SAMPLE_MIN = -11'sd128;
    localparam logic [CODE_BITS-1:0] CODE_TOP  = 4'd15;

    typedef logic signed [6:0] step_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        has;
        logic        last;
        logic [15:0] cnt;
    } res_t;

    function automatic step_t step_val(input logic [CODE_BITS-1:0] code);
        step_t v;
        case (code)
            4'd0:    v = -7'sd34;
            4'd1:    v = -7'sd21;
            4'd2:    v = -7'sd13;
            4'd3:    v = -7'sd8;
            4'd4:    v = -7'sd5;
            4'd5:    v = -7'sd3;
            4'd6:    v = -7'sd2;
            4'd7:    v = -7'sd1;
            4'd8:    v = 7'sd0;
            4'd9:    v = 7'sd1;
            4'd10:   v = 7'sd2;
            4'd11:   v = 7'sd3;
            4'd12:   v = 7'sd5;
            4'd13:   v = 7'sd8;
            4'd14:   v = 7'sd13;
            4'd15:   v = 7'sd21;
            default: v = 7'sd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/fibonacci_delta_audio_encoder.sv]
// Fibonacci delta audio encoder: input register, combinational encoder and a
// four-entry result queue. Depends on fdae_pkg.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  sample   | sample_valid / sample_stall  | sample, start_req, end_req
//  result   | result_valid / result_stall  | out_byte, has_byte, is_last, mismatch_count
//
// One sample per cycle while sample_stall is low: it is held in the input register, then the
// encoder (sixteen adds and fifteen compares) writes up to three results into the queue at once.
// The input register advances while the queue holds at most one result, so after a start
// sample (two or three results) the input stalls until the queue drains to one result.
// Reset clears the input valid flag, predictor, held code, phase, count and the queue.
// A stalled result side backs up through the queue into sample_stall.
module fibonacci_delta_audio_encoder
    import fdae_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  logic signed [7:0] sample,
    input  logic              start_req,
    input  logic              end_req,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        out_byte,
    output logic              has_byte,
    output logic              is_last,
    output logic [15:0]       mismatch_count
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // input register
    logic              in_vld_reg;
    logic signed [7:0] smp_reg;
    logic              start_reg;
    logic              end_reg;

    // encoder state
    logic signed [8:0]       pred_reg,  pred_next;
    logic [CODE_BITS-1:0]    held_reg,  held_next;
    logic                    odd_reg,   odd_next;
    logic [COUNT_BITS-1:0]   mis_reg,   mis_next;

    // result queue
    res_t                  q_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_BITS:0]   q_cnt_reg,  q_cnt_next;

    logic                  advance;
    logic                  pop;
    logic [1:0]            push_n;
    res_t                  res [MAX_RESULTS];

    // encoder signals
    logic signed [8:0]     pred_in;
    logic signed [10:0]    smp_ext;
    logic signed [10:0]    sums [NUM_CODES];
    logic [NUM_CODES-1:0]  le;
    logic [CODE_BITS-1:0]  j_lo, j_sel;
    logic signed [10:0]    sum_sel;
    logic signed [8:0]     pred_enc;
    logic [COUNT_BITS-1:0] mis_base, mis_enc;
    logic [15:0]           cnt_now, cnt_enc;

    assign advance      = in_vld_reg && (q_cnt_reg <= (Q_PTR_BITS+1)'(Q_DEPTH - MAX_RESULTS));
    assign sample_stall = in_vld_reg && !advance;
    assign pop          = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (sample_valid && !sample_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            smp_reg   <= sample;
            start_reg <= start_req;
            end_reg   <= end_req;
        end
    end

    // Encoder: steps rise strictly, so the "sum <= sample" flags form a thermometer
    // and the code is its top set index (four-level binary search), or the next one below range.
    always_comb
    begin
        pred_in = start_reg ? 9'(smp_reg) : pred_reg;
        smp_ext = 11'(smp_reg);
        for (int k = 0; k < NUM_CODES; k++)
        begin
            sums[k] = 11'(pred_in) + 11'(step_val(CODE_BITS'(k)));
            le[k]   = (k == 0) ? 1'b1 : (sums[k] <= smp_ext);
        end
        j_lo[3] = le[8];
        j_lo[2] = le[{j_lo[3], 3'b100}];
        j_lo[1] = le[{j_lo[3], j_lo[2], 2'b10}];
        j_lo[0] = le[{j_lo[3], j_lo[2], j_lo[1], 1'b1}];
        // below the sample range: take the next step up
        if (sums[j_lo] < SAMPLE_MIN && j_lo != CODE_TOP)
        begin
            j_sel = j_lo + 4'd1;
        end
        else
        begin
            j_sel = j_lo;
        end
        sum_sel  = sums[j_sel];
        pred_enc = sum_sel[8:0];
        mis_base = start_reg ? '0 : mis_reg;
        if (pred_enc != 9'(smp_reg) && mis_base != CNT_MAX)
        begin
            mis_enc = mis_base + COUNT_BITS'(1);
        end
        else
        begin
            mis_enc = mis_base;
        end
        cnt_now = 16'(mis_reg);
        cnt_enc = 16'(mis_enc);
    end

    always_comb
    begin
        pred_next = pred_reg;
        held_next = held_reg;
        odd_next  = odd_reg;
        mis_next  = mis_reg;
        push_n    = 2'd0;
        for (int r = 0; r < MAX_RESULTS; r++)
        begin
            res[r] = '{data: PAD_BYTE, has: 1'b0, last: 1'b1, cnt: cnt_now};
        end
        if (in_vld_reg && advance)
        begin
            if (start_reg)
            begin
                res[0]    = '{data: PAD_BYTE, has: 1'b1, last: 1'b0, cnt: '0};
                res[1]    = '{data: smp_reg, has: 1'b1, last: 1'b0, cnt: '0};
                res[2]    = '{data: PAD_BYTE, has: 1'b0, last: 1'b1, cnt: '0};
                mis_next  = '0;
                pred_next = 9'(smp_reg);
                if (end_reg)
                begin
                    push_n    = 2'd3;
                    held_next = '0;
                    odd_next  = 1'b0;
                end
                else
                begin
                    push_n    = 2'd2;
                    held_next = j_sel;
                    odd_next  = 1'b1;
                    pred_next = pred_enc;
                    mis_next  = mis_enc;
                end
            end
            else if (!odd_reg)
            begin
                if (end_reg)
                begin
                    // lone high-nibble sample at the end is dropped
                    push_n = 2'd1;
                end
                else
                begin
                    held_next = j_sel;
                    odd_next  = 1'b1;
                    pred_next = pred_enc;
                    mis_next  = mis_enc;
                end
            end
            else
            begin
                push_n    = 2'd1;
                res[0]    = '{data: {held_reg, j_sel}, has: 1'b1, last: end_reg, cnt: cnt_enc};
                held_next = '0;
                odd_next  = 1'b0;
                pred_next = pred_enc;
                mis_next  = mis_enc;
            end
        end
        q_cnt_next = q_cnt_reg + (Q_PTR_BITS+1)'(push_n) - (Q_PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg   <= '0;
            held_reg   <= '0;
            odd_reg    <= 1'b0;
            mis_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            pred_reg   <= pred_next;
            held_reg   <= held_next;
            odd_reg    <= odd_next;
            mis_reg    <= mis_next;
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(push_n);
            rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(pop);
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // each queue slot takes the result whose offset from the write pointer it sits at
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            logic [Q_PTR_BITS-1:0] ofs;
            ofs = Q_PTR_BITS'(i) - wr_ptr_reg;
            if (2'(ofs) < push_n)
            begin
                q_mem[i] <= res[ofs];
            end
        end
    end

    assign result_valid   = (q_cnt_reg != '0);
    assign out_byte       = q_mem[rd_ptr_reg].data;
    assign has_byte       = q_mem[rd_ptr_reg].has;
    assign is_last        = q_mem[rd_ptr_reg].last;
    assign mismatch_count = q_mem[rd_ptr_reg].cnt;

endmodule
